// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the neuron update RTL.
// Each use expands to one labeled concurrent assertion reporting through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, disabled while the reset is high.
`define SNU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SNU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/snu_pkg.sv =====
// ---------------------------------------------------------------------------
// snu_pkg
// Types, constants and fixed-point helpers of the spiking neuron update block.
// ---------------------------------------------------------------------------
package snu_pkg;

   localparam int NEURONS     = 1024;
   localparam int ADDR_W      = $clog2(NEURONS);
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PIPE_STAGES = 10;

   // Q12.12 state constants
   localparam logic signed [23:0] V_RESET    = -24'sd266240;
   localparam logic signed [23:0] U_INIT     = -24'sd53248;
   localparam logic signed [23:0] FIRE_LEVEL = 24'sd122880;
   localparam logic signed [27:0] LIN_BIAS   = 28'sd573440;

   // fractional coefficients
   localparam logic [15:0]        C004     = 16'd41943;
   localparam logic signed [16:0] C02      = 17'sd13107;
   localparam logic [15:0]        C095     = 16'd62259;
   localparam logic [15:0]        TR_POT   = 16'd6554;
   localparam logic [15:0]        TR_DEP   = 16'd7864;
   localparam logic [62:0]        ROUND_SQ = 63'h0000_0000_8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXCIT_COUNT = 3'd0,
      CSR_RATE_EXC    = 3'd1,
      CSR_RATE_INH    = 3'd2,
      CSR_JUMP_EXC    = 3'd3,
      CSR_JUMP_INH    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0] excit_count;
      logic [15:0]      rate_exc;
      logic [15:0]      rate_inh;
      logic [15:0]      jump_exc;
      logic [15:0]      jump_inh;
   } csr_type;

   typedef struct packed {
      logic signed [23:0] v;
      logic signed [23:0] u;
      logic [15:0]        p;
      logic [15:0]        q;
   } state_word_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      state_word_type    data;
   } mem_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [ADDR_W-1:0]  slot;
      logic               exc;
      logic               fired;
      logic signed [23:0] cur;
      logic signed [23:0] v;
      logic signed [23:0] u;
      logic [15:0]        p;
      logic [15:0]        q;
      logic signed [27:0] lin;
   } ctx_type;

   function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
      logic signed [23:0] r;
      if (x > 48'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (x < -48'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = x[23:0];
      end
      return r;
   endfunction

   // 5v + 140 - u + I, the part of the increment without the square
   function automatic logic signed [27:0] lin_term(input logic signed [23:0] v,
                                                   input logic signed [23:0] u,
                                                   input logic signed [23:0] cur);
      logic signed [27:0] v5;
      v5 = (28'(v) <<< 2) + 28'(v);
      return v5 + LIN_BIAS - 28'(u) + 28'(cur);
   endfunction

   // add the rounded square term, halve by floor, saturate
   function automatic logic signed [23:0] v_next(input logic signed [23:0] v,
                                                 input logic [62:0] prod,
                                                 input logic signed [27:0] lin);
      logic signed [31:0] sum;
      logic signed [31:0] half;
      sum  = $signed({1'b0, prod[62:32]}) + 32'(lin);
      half = sum >>> 1;
      return sat24(48'(v) + 48'(half));
   endfunction

   function automatic logic [15:0] decay(input logic [15:0] t);
      logic [31:0] m;
      m = 32'(t) * 32'(C095) + 32'd32768;
      return m[31:16];
   endfunction

endpackage

// ===== hdl/snu_ram.sv =====
// ---------------------------------------------------------------------------
// snu_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module snu_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/snu_csr.sv =====
// ---------------------------------------------------------------------------
// snu_csr
// Configuration registers: excitatory count and the a and d parameters.
// ---------------------------------------------------------------------------
module snu_csr import snu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output csr_type               cfg
);

   csr_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.excit_count <= CNT_W'(800);
         cfg_ff.rate_exc    <= 16'd1311;
         cfg_ff.rate_inh    <= 16'd6554;
         cfg_ff.jump_exc    <= 16'd32768;
         cfg_ff.jump_inh    <= 16'd8192;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_EXCIT_COUNT: cfg_ff.excit_count <= csr_data[CNT_W-1:0];
            CSR_RATE_EXC:    cfg_ff.rate_exc    <= csr_data;
            CSR_RATE_INH:    cfg_ff.rate_inh    <= csr_data;
            CSR_JUMP_EXC:    cfg_ff.jump_exc    <= csr_data;
            CSR_JUMP_INH:    cfg_ff.jump_inh    <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ===== hdl/snu_pipe.sv =====
// ---------------------------------------------------------------------------
// snu_pipe
// Read-modify-write pipeline: fire check, two Euler half-steps, recovery
// update and trace decay, with write-back and an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module snu_pipe import snu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               hold,
   input  csr_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [IDX_W-1:0]   req_neuron_index,
   input  logic signed [23:0] req_input_current,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_neuron_out,
   output logic               rsp_fired,
   output logic signed [23:0] rsp_membrane_out,
   output logic signed [23:0] rsp_recovery_out,
   output logic [15:0]        rsp_potentiation_out,
   output logic [15:0]        rsp_depression_out,
   output mem_rd_type         rd,
   input  state_word_type     rd_data,
   output mem_wr_type         wr
);

   localparam int LAST = PIPE_STAGES - 1;

   logic [PIPE_STAGES-1:0] vld_ff;
   ctx_type                ctx_ff [PIPE_STAGES];
   ctx_type                ctx_in [PIPE_STAGES];

   logic [46:0]        sq1_ff, sq1_in, sq2_ff, sq2_in;
   logic [62:0]        prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic signed [39:0] m_ff, m_in;
   logic signed [41:0] am_ff, am_in;
   logic signed [47:0] sq1_full, sq2_full;
   logic signed [23:0] target;
   logic signed [24:0] diff;
   logic [15:0]        rate_sel, jump_sel;
   logic signed [23:0] u_out;
   logic               fire_now;
   logic               en, hazard, accept;
   logic [ADDR_W-1:0]  req_slot;

   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic               rsp_fired_ff;
   logic signed [23:0] rsp_v_ff, rsp_u_ff;
   logic [15:0]        rsp_p_ff, rsp_q_ff;

   assign req_slot = ADDR_W'(req_neuron_index % NEURONS);

   // hold a new beat while an older beat of the same neuron is still in flight
   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (vld_ff[k] && (ctx_ff[k].slot == req_slot)) begin
            hazard = 1'b1;
         end
      end
   end

   assign en        = !(vld_ff[LAST] && rsp_valid_ff && rsp_stall);
   assign req_stall = hold || !en || hazard;
   assign accept    = req_valid && !req_stall;

   assign rd.en   = accept;
   assign rd.addr = req_slot;

   assign jump_sel = ctx_ff[0].exc ? cfg.jump_exc : cfg.jump_inh;
   assign fire_now = rd_data.v >= FIRE_LEVEL;
   assign sq1_full = ctx_ff[1].v * ctx_ff[1].v;
   assign sq1_in   = sq1_full[46:0];
   assign prod1_in = 63'(sq1_ff) * 63'(C004) + ROUND_SQ;
   assign sq2_full = ctx_ff[4].v * ctx_ff[4].v;
   assign sq2_in   = sq2_full[46:0];
   assign prod2_in = 63'(sq2_ff) * 63'(C004) + ROUND_SQ;
   assign m_in     = ctx_ff[7].v * C02 + 40'sd32768;
   assign target   = m_ff[39:16];
   assign diff     = 25'(target) - 25'(ctx_ff[8].u);
   assign rate_sel = ctx_ff[8].exc ? cfg.rate_exc : cfg.rate_inh;
   assign am_in    = $signed({1'b0, rate_sel}) * diff + 42'sd32768;
   assign u_out    = sat24(48'(ctx_ff[LAST].u) + 48'(am_ff >>> 16));

   always_comb begin
      ctx_in[0]       = '0;
      ctx_in[0].idx   = req_neuron_index;
      ctx_in[0].slot  = req_slot;
      ctx_in[0].exc   = {1'b0, req_neuron_index} < cfg.excit_count;
      ctx_in[0].cur   = req_input_current;
      for (int k = 1; k < PIPE_STAGES; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end
      // fire: reset v, jump u, set traces; decay the traces right away
      ctx_in[1].fired = fire_now;
      if (fire_now) begin
         ctx_in[1].v = V_RESET;
         ctx_in[1].u = sat24(48'(rd_data.u) + 48'($signed({1'b0, jump_sel})));
         ctx_in[1].p = decay(TR_POT);
         ctx_in[1].q = decay(TR_DEP);
      end else begin
         ctx_in[1].v = rd_data.v;
         ctx_in[1].u = rd_data.u;
         ctx_in[1].p = decay(rd_data.p);
         ctx_in[1].q = decay(rd_data.q);
      end
      ctx_in[2].lin = lin_term(ctx_ff[1].v, ctx_ff[1].u, ctx_ff[1].cur);
      ctx_in[4].v   = v_next(ctx_ff[3].v, prod1_ff, ctx_ff[3].lin);
      ctx_in[5].lin = lin_term(ctx_ff[4].v, ctx_ff[4].u, ctx_ff[4].cur);
      ctx_in[7].v   = v_next(ctx_ff[6].v, prod2_ff, ctx_ff[6].lin);
   end

   always_comb begin
      wr.en     = en && vld_ff[LAST];
      wr.addr   = ctx_ff[LAST].slot;
      wr.data.v = ctx_ff[LAST].v;
      wr.data.u = u_out;
      wr.data.p = ctx_ff[LAST].p;
      wr.data.q = ctx_ff[LAST].q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[PIPE_STAGES-2:0], accept};
         end
         if (wr.en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff   <= ctx_in;
         sq1_ff   <= sq1_in;
         prod1_ff <= prod1_in;
         sq2_ff   <= sq2_in;
         prod2_ff <= prod2_in;
         m_ff     <= m_in;
         am_ff    <= am_in;
      end
      if (wr.en) begin
         rsp_idx_ff   <= ctx_ff[LAST].idx;
         rsp_fired_ff <= ctx_ff[LAST].fired;
         rsp_v_ff     <= ctx_ff[LAST].v;
         rsp_u_ff     <= u_out;
         rsp_p_ff     <= ctx_ff[LAST].p;
         rsp_q_ff     <= ctx_ff[LAST].q;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_neuron_out       = rsp_idx_ff;
   assign rsp_fired            = rsp_fired_ff;
   assign rsp_membrane_out     = rsp_v_ff;
   assign rsp_recovery_out     = rsp_u_ff;
   assign rsp_potentiation_out = rsp_p_ff;
   assign rsp_depression_out   = rsp_q_ff;

   `SNU_ASSERT(a_no_slot_clash, clock, reset, (accept && wr.en) |-> (rd.addr != wr.addr), "read of a neuron being written back")
   `SNU_ASSERT(a_wb_fills_out, clock, reset, wr.en |=> rsp_valid_ff, "write-back without result beat")

endmodule

// ===== hdl/spiking_neuron_update.sv =====
// Throughput: one neuron per cycle unless held, set by the single read and write
// port of the state memory; a neuron that is still in the 10-stage pipeline waits
// for its write-back, and a stalled response beat or the clear pass holds requests.
// After reset the state memory is cleared to its initial values, one entry per
// cycle, before the first request.
// Configuration registers take reset values at once and accept writes at any time.
// ---------------------------------------------------------------------------
// spiking_neuron_update
// Quadratic spiking neuron update with potentiation and depression traces, state
// held per neuron in one memory and updated by a read-modify-write pipeline.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spiking_neuron_update import snu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [IDX_W-1:0]      req_neuron_index,
   input  logic signed [23:0]    req_input_current,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_W-1:0]      rsp_neuron_out,
   output logic                  rsp_fired,
   output logic signed [23:0]    rsp_membrane_out,
   output logic signed [23:0]    rsp_recovery_out,
   output logic [15:0]           rsp_potentiation_out,
   output logic [15:0]           rsp_depression_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int WORD_W = $bits(state_word_type);

   csr_type           cfg;
   mem_rd_type        pipe_rd;
   mem_wr_type        pipe_wr;
   state_word_type    rd_word, clr_word;
   logic [WORD_W-1:0] ram_rdata;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // sweep the memory with initial values after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(NEURONS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      clr_word.v = V_RESET;
      clr_word.u = U_INIT;
      clr_word.p = '0;
      clr_word.q = '0;
      if (clr_busy_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = clr_word;
      end else begin
         ram_we    = pipe_wr.en;
         ram_waddr = pipe_wr.addr;
         ram_wdata = pipe_wr.data;
      end
   end

   assign rd_word = state_word_type'(ram_rdata);

   snu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   snu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NEURONS)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (pipe_rd.en),
      .raddr (pipe_rd.addr),
      .rdata (ram_rdata)
   );

   snu_pipe u_pipe (
      .clock                (clock),
      .reset                (reset),
      .hold                 (clr_busy_ff),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_neuron_index     (req_neuron_index),
      .req_input_current    (req_input_current),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_neuron_out       (rsp_neuron_out),
      .rsp_fired            (rsp_fired),
      .rsp_membrane_out     (rsp_membrane_out),
      .rsp_recovery_out     (rsp_recovery_out),
      .rsp_potentiation_out (rsp_potentiation_out),
      .rsp_depression_out   (rsp_depression_out),
      .rd                   (pipe_rd),
      .rd_data              (rd_word),
      .wr                   (pipe_wr)
   );

   `SNU_ASSERT_ALWAYS(a_reset_starts_clear, clock, reset |=> clr_busy_ff, "clear pass not started by reset")
   `SNU_ASSERT(a_clear_blocks_wb, clock, reset, clr_busy_ff |-> !pipe_wr.en, "write-back during clear pass")
   `SNU_ASSERT(a_clear_once, clock, reset, !clr_busy_ff |=> !clr_busy_ff, "clear pass restarted without reset")

endmodule
